// ----- hdl/lcb_pkg.sv -----
package lcb_pkg;

    // item opcodes
    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_EPOCH = 1'b1
    } t_op;

    // configuration register indexes
    typedef enum logic {
        CFG_FACE_COUNT = 1'b0,
        CFG_LAMBERT    = 1'b1
    } t_cfg_idx;

    // back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // one queued item, already classified
    typedef struct packed {
        t_op                op;
        logic [9:0]         idx;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [15:0]        area;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] oz;
    } t_item;

    // configuration seen by the back end
    typedef struct packed {
        logic [10:0] face_count;
        logic [16:0] lambert;
    } t_cfg;

    localparam int          DIV_STEPS = 16;
    localparam logic [16:0] ONE_Q16   = 17'h10000;
    localparam logic [43:0] SUM_MAX   = 44'hFFF_FFFF_FFFF;
    localparam logic [10:0] FC_RESET  = 11'd1024;

endpackage

// ----- hdl/lcb_front.sv -----
module lcb_front import lcb_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [0:0]         i_opcode,
    input  logic [9:0]         i_face_index,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic [15:0]        i_facet_area,
    input  logic signed [15:0] i_sun_x,
    input  logic signed [15:0] i_sun_y,
    input  logic signed [15:0] i_sun_z,
    input  logic signed [15:0] i_obs_x,
    input  logic signed [15:0] i_obs_y,
    input  logic signed [15:0] i_obs_z,
    output logic               o_q_valid,
    output t_item              o_q_item,
    input  logic               i_q_pop
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;

    // classify the incoming item
    always_comb begin
        w_item      = '0;
        w_item.op   = t_op'(i_opcode);
        w_item.idx  = i_face_index;
        w_item.nx   = i_normal_x;
        w_item.ny   = i_normal_y;
        w_item.nz   = i_normal_z;
        w_item.area = i_facet_area;
        w_item.sx   = i_sun_x;
        w_item.sy   = i_sun_y;
        w_item.sz   = i_sun_z;
        w_item.ox   = i_obs_x;
        w_item.oy   = i_obs_y;
        w_item.oz   = i_obs_z;
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    // two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            case ({w_push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hdl/lcb_back.sv -----
module lcb_back import lcb_pkg::*; #(
    parameter int MAX_FACES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [43:0] o_brightness
);

    localparam int AW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
    localparam int CW = $clog2(MAX_FACES + 1);

    // facet memory
    logic [47:0] normal_mem [MAX_FACES];
    logic [15:0] area_mem   [MAX_FACES];

    t_state r_state, n_state;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_n;
    logic [CW-1:0] w_n_clamp;
    logic [16:0]   w_c_clamp;
    logic [16:0]   r_c;
    logic signed [15:0] r_sun [3];
    logic signed [15:0] r_obs [3];
    logic w_load_we, w_start, w_issue, w_last;
    logic [AW-1:0] w_wr_addr;
    logic [AW-1:0] w_rd_addr;

    // read stage
    logic        r_v0, r_l0;
    logic [47:0] r_rd_nrm;
    logic [15:0] r_rd_area;
    // product stage
    logic        r_v1, r_l1;
    logic signed [31:0] r_p [6];
    logic [15:0] r_a1;
    // dot stage
    logic        r_v2, r_l2;
    logic signed [33:0] r_mu0, r_mu;
    logic [15:0] r_a2;
    // divider stages
    logic        r_dv   [DIV_STEPS+1];
    logic        r_dl   [DIV_STEPS+1];
    logic        r_dp   [DIV_STEPS+1];
    logic [32:0] r_drem [DIV_STEPS+1];
    logic [32:0] r_dden [DIV_STEPS+1];
    logic [15:0] r_dq   [DIV_STEPS+1];
    logic [16:0] r_dmq  [DIV_STEPS+1];
    logic [15:0] r_da   [DIV_STEPS+1];
    // weighting stages
    logic        r_v4, r_l4, r_p4;
    logic [32:0] r_wa;
    logic [33:0] r_wb;
    logic [15:0] r_a4;
    logic        r_v5, r_l5, r_p5;
    logic [32:0] r_s;
    logic [15:0] r_a5;
    logic        r_tv, r_tl;
    logic [32:0] r_t;
    // accumulator and output
    logic [43:0] r_acc;
    logic        r_out_valid;
    logic [43:0] r_out;
    logic [44:0] w_sum;
    logic [43:0] w_sum_sat;

    // clamp configuration
    always_comb begin
        if (32'(i_cfg.face_count) > MAX_FACES) w_n_clamp = CW'(MAX_FACES);
        else w_n_clamp = CW'(i_cfg.face_count);
        if (i_cfg.lambert > ONE_Q16) w_c_clamp = ONE_Q16;
        else w_c_clamp = i_cfg.lambert;
    end

    assign w_last    = (r_k == r_n - CW'(1));
    assign w_wr_addr = AW'(i_q_item.idx);
    assign w_rd_addr = AW'(r_k);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_start && w_n_clamp != '0) n_state = ST_RUN;
            ST_RUN:   if (w_last) n_state = ST_DRAIN;
            ST_DRAIN: if (r_tv && r_tl) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_q_pop   = 1'b0;
        w_load_we = 1'b0;
        w_start   = 1'b0;
        w_issue   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.op == OP_LOAD) begin
                        o_q_pop   = 1'b1;
                        w_load_we = (32'(i_q_item.idx) < MAX_FACES);
                    end else if (!r_out_valid) begin
                        o_q_pop = 1'b1;
                        w_start = 1'b1;
                    end
                end
            end
            ST_RUN:   w_issue = 1'b1;
            ST_DRAIN: w_issue = 1'b0;
            default:  w_issue = 1'b0;
        endcase
    end

    // facet memory write and registered read
    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            normal_mem[w_wr_addr] <= {i_q_item.nx, i_q_item.ny, i_q_item.nz};
            area_mem[w_wr_addr]   <= i_q_item.area;
        end
        r_rd_nrm  <= normal_mem[w_rd_addr];
        r_rd_area <= area_mem[w_rd_addr];
    end

    // epoch capture and facet counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if (w_start) r_k <= '0;
            else if (w_issue) r_k <= r_k + CW'(1);
        end
        if (w_start) begin
            r_n      <= w_n_clamp;
            r_c      <= w_c_clamp;
            r_sun[0] <= i_q_item.sx;
            r_sun[1] <= i_q_item.sy;
            r_sun[2] <= i_q_item.sz;
            r_obs[0] <= i_q_item.ox;
            r_obs[1] <= i_q_item.oy;
            r_obs[2] <= i_q_item.oz;
        end
    end

    // valid flags along the pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_tv <= 1'b0;
            for (int j = 0; j <= DIV_STEPS; j++) r_dv[j] <= 1'b0;
        end else begin
            r_v0 <= w_issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_dv[0] <= r_v2;
            for (int j = 0; j < DIV_STEPS; j++) r_dv[j+1] <= r_dv[j];
            r_v4 <= r_dv[DIV_STEPS];
            r_v5 <= r_v4;
            r_tv <= r_v5;
        end
    end

    // products of normal with sun and observer
    always_ff @(posedge i_clk) begin
        r_l0 <= w_last;
        r_l1 <= r_l0;
        r_a1 <= r_rd_area;
        r_p[0] <= $signed(r_rd_nrm[47:32]) * r_sun[0];
        r_p[1] <= $signed(r_rd_nrm[31:16]) * r_sun[1];
        r_p[2] <= $signed(r_rd_nrm[15:0])  * r_sun[2];
        r_p[3] <= $signed(r_rd_nrm[47:32]) * r_obs[0];
        r_p[4] <= $signed(r_rd_nrm[31:16]) * r_obs[1];
        r_p[5] <= $signed(r_rd_nrm[15:0])  * r_obs[2];
    end

    // dot products, Q4.30
    always_ff @(posedge i_clk) begin
        r_l2  <= r_l1;
        r_a2  <= r_a1;
        r_mu0 <= 34'(r_p[0]) + 34'(r_p[1]) + 34'(r_p[2]);
        r_mu  <= 34'(r_p[3]) + 34'(r_p[4]) + 34'(r_p[5]);
    end

    // divider entry and one quotient bit per stage
    always_ff @(posedge i_clk) begin
        logic        pos;
        logic [33:0] trial;
        pos = (r_mu0 > 34'sd0) && (r_mu > 34'sd0);
        r_dl[0] <= r_l2;
        r_da[0] <= r_a2;
        r_dp[0] <= pos;
        r_dq[0] <= '0;
        if (pos) begin
            r_drem[0] <= r_mu0[32:0];
            r_dden[0] <= r_mu0[32:0] + r_mu[32:0];
            if (r_mu0[32:14] > 19'(ONE_Q16)) r_dmq[0] <= ONE_Q16;
            else r_dmq[0] <= r_mu0[30:14];
        end else begin
            r_drem[0] <= '0;
            r_dden[0] <= 33'd1;
            r_dmq[0]  <= '0;
        end
        for (int j = 0; j < DIV_STEPS; j++) begin
            trial = {r_drem[j], 1'b0};
            if (trial >= {1'b0, r_dden[j]}) begin
                r_drem[j+1] <= 33'(trial - {1'b0, r_dden[j]});
                r_dq[j+1]   <= {r_dq[j][14:0], 1'b1};
            end else begin
                r_drem[j+1] <= trial[32:0];
                r_dq[j+1]   <= {r_dq[j][14:0], 1'b0};
            end
            r_dden[j+1] <= r_dden[j];
            r_dl[j+1]   <= r_dl[j];
            r_dp[j+1]   <= r_dp[j];
            r_dmq[j+1]  <= r_dmq[j];
            r_da[j+1]   <= r_da[j];
        end
    end

    // blend of scattering laws, then area weighting
    always_ff @(posedge i_clk) begin
        r_l4 <= r_dl[DIV_STEPS];
        r_p4 <= r_dp[DIV_STEPS];
        r_a4 <= r_da[DIV_STEPS];
        r_wa <= (ONE_Q16 - r_c) * r_dq[DIV_STEPS];
        r_wb <= r_c * r_dmq[DIV_STEPS];
        r_l5 <= r_l4;
        r_p5 <= r_p4;
        r_a5 <= r_a4;
        r_s  <= 33'(34'(r_wa) + r_wb);
        r_tl <= r_l5;
        if (r_p5) r_t <= 33'((49'(r_a5) * 49'(r_s)) >> 16);
        else r_t <= '0;
    end

    assign w_sum     = {1'b0, r_acc} + 45'(r_t);
    assign w_sum_sat = w_sum[44] ? SUM_MAX : w_sum[43:0];

    // saturating accumulator
    always_ff @(posedge i_clk) begin
        if (w_start) r_acc <= '0;
        else if (r_tv) r_acc <= w_sum_sat;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            if (w_start && w_n_clamp == '0) begin
                r_out_valid <= 1'b1;
                r_out       <= '0;
            end else if (r_tv && r_tl) begin
                r_out_valid <= 1'b1;
                r_out       <= w_sum_sat;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_brightness = r_out;

endmodule

// ----- hdl/faceted_lightcurve_brightness_top.sv -----
// Faceted lightcurve brightness unit.
// Input channel (i_valid/o_ready): one item per handshake. A load item
// (opcode 0) writes facet i_face_index; an epoch item (opcode 1) sums the
// shaded facet terms for the given sun and observer directions.
// Output channel (o_valid/i_ready): one brightness result per epoch item.
// Config channel (i_cfg_valid/o_cfg_ready): index 0 face_count, index 1
// lambert_weight; write only while the block is idle.
// Timing: items pass a two-entry queue to the engine. An epoch issues one
// facet read per cycle for face_count facets, then drains the pipeline
// (memory read, dot products, 16-stage divider, weighting multipliers,
// accumulator). Epochs run one at a time; each drains before the next.
// Reset clears the queue, the result register and the sequencer and sets
// face_count to 1024 and lambert_weight to 0; facet memory is not cleared.
// When the receiver stalls, the result waits in the output register; loads
// ahead of the next epoch proceed; it starts once the result is taken.
module faceted_lightcurve_brightness_top import lcb_pkg::*; #(
    parameter int MAX_FACES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [0:0]         i_opcode,
    input  logic [9:0]         i_face_index,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic [15:0]        i_facet_area,
    input  logic signed [15:0] i_sun_x,
    input  logic signed [15:0] i_sun_y,
    input  logic signed [15:0] i_sun_z,
    input  logic signed [15:0] i_obs_x,
    input  logic signed [15:0] i_obs_y,
    input  logic signed [15:0] i_obs_z,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [43:0]        o_brightness,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data
);

    t_cfg  r_cfg;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_q_pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.face_count <= FC_RESET;
            r_cfg.lambert    <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FACE_COUNT: r_cfg.face_count <= i_cfg_data[10:0];
                CFG_LAMBERT:    r_cfg.lambert    <= i_cfg_data;
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    lcb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_face_index (i_face_index),
        .i_normal_x   (i_normal_x),
        .i_normal_y   (i_normal_y),
        .i_normal_z   (i_normal_z),
        .i_facet_area (i_facet_area),
        .i_sun_x      (i_sun_x),
        .i_sun_y      (i_sun_y),
        .i_sun_z      (i_sun_z),
        .i_obs_x      (i_obs_x),
        .i_obs_y      (i_obs_y),
        .i_obs_z      (i_obs_z),
        .o_q_valid    (w_q_valid),
        .o_q_item     (w_q_item),
        .i_q_pop      (w_q_pop)
    );

    lcb_back #(.MAX_FACES(MAX_FACES)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .o_q_pop      (w_q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_brightness (o_brightness)
    );

endmodule

// ----- hdl/lcb_checker.sv -----
module lcb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [43:0] o_brightness,
    input logic        o_cfg_ready
);

    // reset empties the result register
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // reset empties the input queue
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> o_ready)
        else $error("input not ready after reset");

    // config port never stalls
    a_cfg_rdy: assert property (@(posedge i_clk) o_cfg_ready)
        else $error("config port stalled");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_brightness))
        else $error("stalled result changed");

endmodule

bind faceted_lightcurve_brightness_top lcb_checker u_lcb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_brightness (o_brightness),
    .o_cfg_ready  (o_cfg_ready)
);
